>>> design/rpvm_pkg.sv
// Package for the RF power response / VSWR monitor.
// Holds the widths, the character codes, the command and status structs shared by the modules.
// Depends on nothing.
package rpvm_pkg;

  localparam int COUNT_BITS = 16;
  localparam logic [16:0] PWR_MAX  = 17'd99999;
  localparam logic [16:0] VSWR_MAX = 17'd99999;
  localparam logic [13:0] RL_MAX   = 14'd9999;
  localparam logic signed [14:0] DBM_FLOOR = -15'sd9990;
  localparam logic [20:0] DBM_K = 21'd1972830;
  localparam logic [24:0] RL_K  = 25'd19728302;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FORMAT  = 2'd1;
  localparam logic [1:0] ST_FWDZERO = 2'd2;
  localparam logic [1:0] ST_NOTABOVE = 2'd3;

  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  localparam logic CFG_OVR_FWD = 1'b0;
  localparam logic CFG_OVR_REF = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic take;      // consume character
    logic start;     // latch operands, check status
    logic log_f;     // run log on forward
    logic log_r;     // run log on reflected
    logic div_rho;   // R<<32 / F
    logic sqrt_rho;
    logic div_vswr;
    logic div_eff;
    logic mul_fdbm;
    logic mul_rdbm;
    logic mul_rl;
    logic commit;    // update held values
    logic finish;    // load output register, clear parse state
  } rpvm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;      // iterative unit running
    logic calc;      // status ok, run the math
  } rpvm_sts_t;

endpackage

>>> design/rpvm_if.sv
// Valid/ready channel interfaces for the monitor.
// Does not depend on rpvm_pkg; the field widths are literal.
interface rpvm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

interface rpvm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [16:0]        forward_power;
  logic [16:0]        reflected_power;
  logic signed [14:0] forward_dbm;
  logic signed [14:0] reflected_dbm;
  logic [16:0]        vswr;
  logic [13:0]        return_loss;
  logic [15:0]        rho;
  logic [16:0]        efficiency;
  logic               alarm;
  logic               alarm_on_zero_power;
  logic [15:0]        rx_count;
  modport source (output valid, status, forward_power, reflected_power, forward_dbm,
                  reflected_dbm, vswr, return_loss, rho, efficiency, alarm,
                  alarm_on_zero_power, rx_count, input ready);
  modport sink (input valid, status, forward_power, reflected_power, forward_dbm,
                reflected_dbm, vswr, return_loss, rho, efficiency, alarm,
                alarm_on_zero_power, rx_count, output ready);
endinterface

interface rpvm_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/rf_power_response_vswr_monitor.sv
// Top level of the RF power response / VSWR monitor.
// Depends on rpvm_pkg, rpvm_if, rpvm_ctrl and rpvm_dpath.
//
//  channel   | dir | payload
//  in_ch     | in  | char_code[7:0], last_char
//  cfg_ch    | in  | index, data[16:0]
//  out_ch    | out | status .. rx_count, twelve fields
//
// A character that is not last is taken whenever it is valid in the parse state.
// After a last character no input is taken until the result is loaded: two
// 16-squaring logs, three multiplies, three 64-step divides and a 17-step square
// root run on the shared units when the status is ok; else logs and dBm products.
// Reset (rst, synchronous) clears parser, counter, held values and overrides.
// A full output register stalls the controller before it loads the next result.
module rf_power_response_vswr_monitor
  import rpvm_pkg::*;
(
  input logic          clk,
  input logic          rst,
  rpvm_in_if.sink      in_ch,
  rpvm_cfg_if.sink     cfg_ch,
  rpvm_out_if.source   out_ch
);

  rpvm_cmd_t   cmd;
  rpvm_sts_t   sts;
  logic [16:0] ovr_fwd, ovr_ref;
  logic        out_valid;

  logic [1:0]         r_status;
  logic [16:0]        r_fwd, r_ref, r_vswr, r_eff;
  logic signed [14:0] r_fdbm, r_rdbm;
  logic [13:0]        r_rl;
  logic [15:0]        r_rho, r_count;
  logic               r_alarm, r_azp;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ovr_fwd <= '0;
      ovr_ref <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_OVR_FWD) ovr_fwd <= cfg_ch.data;
      else ovr_ref <= cfg_ch.data;
    end
  end

  rpvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_char),
    .in_ready (in_ch.ready),
    .out_free (!out_valid || out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpvm_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (in_ch.char_code),
    .ovr_fwd   (ovr_fwd),
    .ovr_ref   (ovr_ref),
    .r_status  (r_status),
    .r_fwd     (r_fwd),
    .r_ref     (r_ref),
    .r_fdbm    (r_fdbm),
    .r_rdbm    (r_rdbm),
    .r_vswr    (r_vswr),
    .r_rl      (r_rl),
    .r_rho     (r_rho),
    .r_eff     (r_eff),
    .r_alarm   (r_alarm),
    .r_azp     (r_azp),
    .r_count   (r_count)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ch.status <= r_status;
      out_ch.forward_power <= r_fwd;
      out_ch.reflected_power <= r_ref;
      out_ch.forward_dbm <= r_fdbm;
      out_ch.reflected_dbm <= r_rdbm;
      out_ch.vswr <= r_vswr;
      out_ch.return_loss <= r_rl;
      out_ch.rho <= r_rho;
      out_ch.efficiency <= r_eff;
      out_ch.alarm <= r_alarm;
      out_ch.alarm_on_zero_power <= r_azp;
      out_ch.rx_count <= r_count;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

>>> design/rpvm_ctrl.sv
// Controller state machine: sequences parsing and the iterative math steps.
// Depends on rpvm_pkg.
module rpvm_ctrl
  import rpvm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  logic      out_free,
  input  rpvm_sts_t sts,
  output rpvm_cmd_t cmd
);

  typedef enum logic [13:0] {
    S_PARSE = 14'b00000000000001,
    S_START = 14'b00000000000010,
    S_LOGF  = 14'b00000000000100,
    S_LOGR  = 14'b00000000001000,
    S_MULF  = 14'b00000000010000,
    S_MULR  = 14'b00000000100000,
    S_MULL  = 14'b00000001000000,
    S_DIVR  = 14'b00000010000000,
    S_SQRT  = 14'b00000100000000,
    S_DIVV  = 14'b00001000000000,
    S_DIVE  = 14'b00010000000000,
    S_COMM  = 14'b00100000000000,
    S_WAIT  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   launched, launched_next;

  assign in_ready = (state == S_PARSE);

  // each unit state launches once, then waits for busy to drop
  always_comb begin
    cmd = '0;
    state_next = state;
    launched_next = launched;
    case (state)
      S_PARSE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) state_next = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_next = S_LOGF;
      end
      S_LOGF, S_LOGR, S_MULF, S_MULR, S_MULL, S_DIVR, S_SQRT, S_DIVV, S_DIVE: begin
        if (!launched) begin
          launched_next = 1'b1;
          cmd.log_f    = (state == S_LOGF);
          cmd.log_r    = (state == S_LOGR);
          cmd.mul_fdbm = (state == S_MULF);
          cmd.mul_rdbm = (state == S_MULR);
          cmd.mul_rl   = (state == S_MULL);
          cmd.div_rho  = (state == S_DIVR);
          cmd.sqrt_rho = (state == S_SQRT);
          cmd.div_vswr = (state == S_DIVV);
          cmd.div_eff  = (state == S_DIVE);
        end else if (!sts.busy) begin
          launched_next = 1'b0;
          case (state)
            S_LOGF: state_next = S_LOGR;
            S_LOGR: state_next = S_MULF;
            S_MULF: state_next = S_MULR;
            S_MULR: state_next = sts.calc ? S_MULL : S_WAIT;
            S_MULL: state_next = S_DIVR;
            S_DIVR: state_next = S_SQRT;
            S_SQRT: state_next = S_DIVV;
            S_DIVV: state_next = S_DIVE;
            S_DIVE: state_next = S_COMM;
            default: state_next = S_WAIT;
          endcase
        end
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_PARSE;
      end
      default: state_next = S_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PARSE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      launched <= launched_next;
    end
  end

endmodule

>>> design/rpvm_dpath.sv
// Datapath: character parser, shared multiply, divide, square root and log units.
// Depends on rpvm_pkg.
module rpvm_dpath
  import rpvm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  rpvm_cmd_t          cmd,
  output rpvm_sts_t          sts,
  input  logic [7:0]         char_code,
  input  logic [16:0]        ovr_fwd,
  input  logic [16:0]        ovr_ref,
  output logic [1:0]         r_status,
  output logic [16:0]        r_fwd,
  output logic [16:0]        r_ref,
  output logic signed [14:0] r_fdbm,
  output logic signed [14:0] r_rdbm,
  output logic [16:0]        r_vswr,
  output logic [13:0]        r_rl,
  output logic [15:0]        r_rho,
  output logic [16:0]        r_eff,
  output logic               r_alarm,
  output logic               r_azp,
  output logic [15:0]        r_count
);

  // ---------------- parser
  logic [3:0]  char_position;
  logic        format_bad, alarm_seen, zero_power_digit;
  logic [16:0] forward_accum, reflected_accum;
  logic [COUNT_BITS-1:0] good_responses;
  logic        is_dig;
  logic [3:0]  dig, body;
  logic [16:0] fwd_mac, ref_mac;

  assign is_dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dig = 4'(char_code - CH_ZERO);
  assign body = (char_position == 4'd0) ? 4'd0 : char_position - 4'd1;
  assign fwd_mac = 17'(({forward_accum, 3'b000}) + ({forward_accum, 1'b0}) + 20'(dig));
  assign ref_mac = 17'(({reflected_accum, 3'b000}) + ({reflected_accum, 1'b0}) + 20'(dig));

  // ---------------- operand/result registers
  logic [16:0] fw, rf;
  logic [1:0]  status;
  logic        calc;
  logic [20:0] lf, lr;        // log2 Q5.16
  logic signed [14:0] fdbm, rdbm;
  logic [15:0] q;
  logic [16:0] held_vswr, held_efficiency;
  logic [13:0] held_return_loss;
  logic [15:0] held_rho;
  logic [16:0] vswr_new, eff_new;
  logic [13:0] rl_new;

  // ---------------- log unit: 16 squarings, one per cycle
  logic        log_busy;
  logic [4:0]  log_cnt;
  logic [31:0] log_x;      // Q2.30 mantissa
  logic [15:0] log_f;
  logic [63:0] log_sq;
  logic [31:0] log_sh;
  logic [4:0]  msb_pos;
  logic [16:0] log_src;
  logic        log_sel_r;
  logic [4:0]  log_e;

  assign log_src = cmd.log_f ? fw : rf;
  always_comb begin
    msb_pos = 5'd0;
    for (int i = 0; i < 17; i++) if (log_src[i]) msb_pos = 5'(i);
  end
  assign log_sq = log_x * log_x;
  assign log_sh = log_sq[61:30];

  // ---------------- multiplier for dBm and return loss (25x21 wide, one shot)
  logic        mul_busy;
  logic [63:0] mul_p;
  logic [63:0] mul_r;
  logic [1:0]  mul_sel;

  assign mul_r = mul_p + 64'h80000000;

  // ---------------- shared restoring divider, 64/17 -> 33 quotient bits
  logic        div_busy;
  logic [6:0]  div_cnt;
  logic [63:0] div_num;
  logic [17:0] div_rem;
  logic [16:0] div_den;
  logic [32:0] div_quo;
  logic [17:0] div_trial;
  logic [18:0] div_sub;
  logic [1:0]  div_sel;

  assign div_trial = {div_rem[16:0], div_num[63]};
  assign div_sub = {1'b0, div_trial} - {2'b00, div_den};

  // ---------------- square root, 2 bits per cycle
  logic        sq_busy;
  logic [4:0]  sq_cnt;
  logic [33:0] sq_v;
  logic [33:0] sq_r, sq_bit;
  logic [33:0] sq_rb;
  assign sq_rb = sq_r + sq_bit;

  logic [16:0] d_vswr;
  assign d_vswr = 17'h10000 - {1'b0, q};

  assign sts.busy = log_busy | mul_busy | div_busy | sq_busy;
  assign sts.calc = calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      format_bad <= 1'b0;
      forward_accum <= '0;
      reflected_accum <= '0;
      alarm_seen <= 1'b0;
      zero_power_digit <= 1'b0;
      good_responses <= '0;
      held_vswr <= '0;
      held_return_loss <= '0;
      held_rho <= '0;
      held_efficiency <= '0;
      log_busy <= 1'b0;
      mul_busy <= 1'b0;
      div_busy <= 1'b0;
      sq_busy <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (char_position == 4'd0 && char_code == CH_GT) begin
          char_position <= 4'd1;
        end else begin
          case (body)
            4'd0, 4'd1, 4'd2, 4'd4: begin
              if (is_dig) forward_accum <= fwd_mac; else format_bad <= 1'b1;
            end
            4'd6, 4'd7, 4'd9, 4'd10: begin
              if (is_dig) reflected_accum <= ref_mac; else format_bad <= 1'b1;
            end
            4'd3, 4'd8: if (char_code != CH_DOT) format_bad <= 1'b1;
            4'd5: if (char_code != CH_COMMA) format_bad <= 1'b1;
            4'd11: begin
              if (is_dig || char_code == CH_E_LO || char_code == CH_E_UP) format_bad <= 1'b1;
              alarm_seen <= (char_code == CH_A);
            end
            4'd12: begin
              if (!is_dig) format_bad <= 1'b1;
              zero_power_digit <= (char_code == CH_ONE);
            end
            default: format_bad <= 1'b1;
          endcase
          if (char_position == 4'd0) char_position <= 4'd2;
          else if (char_position < 4'd15) char_position <= char_position + 4'd1;
        end
      end
      if (cmd.start && !(format_bad || char_position != 4'd14)) begin
        good_responses <= good_responses + 1'b1;
      end
      if (cmd.commit) begin
        held_vswr <= vswr_new;
        held_return_loss <= rl_new;
        held_rho <= q;
        held_efficiency <= eff_new;
      end
      if (cmd.finish) begin
        char_position <= '0;
        format_bad <= 1'b0;
        forward_accum <= '0;
        reflected_accum <= '0;
        alarm_seen <= 1'b0;
        zero_power_digit <= 1'b0;
      end
      if (cmd.log_f || cmd.log_r) log_busy <= 1'b1;
      else if (log_busy && log_cnt == 5'd16) log_busy <= 1'b0;
      if (cmd.mul_fdbm || cmd.mul_rdbm || cmd.mul_rl) mul_busy <= 1'b1;
      else mul_busy <= 1'b0;
      if (cmd.div_rho || cmd.div_vswr || cmd.div_eff) div_busy <= 1'b1;
      else if (div_busy && div_cnt == 7'd64) div_busy <= 1'b0;
      if (cmd.sqrt_rho) sq_busy <= 1'b1;
      else if (sq_busy && sq_cnt == 5'd17) sq_busy <= 1'b0;
    end
  end

  // payload side of the units
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      if (format_bad || char_position != 4'd14) begin
        status <= ST_FORMAT;
        fw <= '0;
        rf <= '0;
        calc <= 1'b0;
      end else begin
        logic [16:0] f_v, r_v;
        if (ovr_fwd != '0) begin
          f_v = (ovr_fwd > PWR_MAX) ? PWR_MAX : ovr_fwd;
          r_v = (ovr_ref > PWR_MAX) ? PWR_MAX : ovr_ref;
        end else begin
          f_v = 17'(forward_accum * 17'd10);
          r_v = reflected_accum;
        end
        fw <= f_v;
        rf <= r_v;
        if (f_v == '0) begin
          status <= ST_FWDZERO;
          calc <= 1'b0;
        end else if (f_v <= r_v) begin
          status <= ST_NOTABOVE;
          calc <= 1'b0;
        end else begin
          status <= ST_OK;
          calc <= 1'b1;
        end
      end
    end

    // log: mantissa normalized to Q2.30, then squaring for fraction bits
    if (cmd.log_f || cmd.log_r) begin
      log_x <= 32'({15'd0, log_src} << (5'd30 - msb_pos));
      log_f <= '0;
      log_cnt <= '0;
      log_sel_r <= cmd.log_r;
      log_e <= msb_pos;
    end else if (log_busy && log_cnt != 5'd16) begin
      log_cnt <= log_cnt + 5'd1;
      if (log_sh[31]) begin
        log_x <= {1'b0, log_sh[31:1]};
        log_f <= {log_f[14:0], 1'b1};
      end else begin
        log_x <= log_sh;
        log_f <= {log_f[14:0], 1'b0};
      end
    end else if (log_busy) begin
      if (log_sel_r) lr <= {log_e, log_f};
      else lf <= {log_e, log_f};
    end

    // multiplier, one product per launch
    if (cmd.mul_fdbm) begin
      mul_p <= 64'(lf) * 64'(DBM_K);
      mul_sel <= 2'd0;
    end else if (cmd.mul_rdbm) begin
      mul_p <= 64'(lr) * 64'(DBM_K);
      mul_sel <= 2'd1;
    end else if (cmd.mul_rl) begin
      mul_p <= 64'((lf > lr) ? lf - lr : 21'd0) * 64'(RL_K);
      mul_sel <= 2'd2;
    end else if (mul_busy) begin
      case (mul_sel)
        2'd0: fdbm <= (fw == '0) ? DBM_FLOOR : 15'(mul_r[63:32] + 32'd100);
        2'd1: rdbm <= (rf == '0) ? DBM_FLOOR : 15'(mul_r[63:32] + 32'd100);
        default: begin
          if (rf == '0) rl_new <= RL_MAX;
          else rl_new <= (mul_r[63:32] > 32'(RL_MAX)) ? RL_MAX : 14'(mul_r[45:32]);
        end
      endcase
    end

    // divider
    if (cmd.div_rho) begin
      div_num <= {15'd0, rf, 32'd0};
      div_den <= fw;
      div_sel <= 2'd0;
    end else if (cmd.div_vswr) begin
      div_num <= 64'((64'd100 * (64'h10000 + 64'(q))) + 64'(d_vswr >> 1));
      div_den <= d_vswr;
      div_sel <= 2'd1;
    end else if (cmd.div_eff) begin
      div_num <= 64'(({47'd0, 17'(fw - rf)} << 16) + 64'(fw >> 1));
      div_den <= fw;
      div_sel <= 2'd2;
    end
    if (cmd.div_rho || cmd.div_vswr || cmd.div_eff) begin
      div_rem <= '0;
      div_quo <= '0;
      div_cnt <= '0;
    end else if (div_busy && div_cnt != 7'd64) begin
      div_cnt <= div_cnt + 7'd1;
      div_num <= {div_num[62:0], 1'b0};
      if (!div_sub[18]) begin
        div_rem <= div_sub[17:0];
        div_quo <= {div_quo[31:0], 1'b1};
      end else begin
        div_rem <= div_trial;
        div_quo <= {div_quo[31:0], 1'b0};
      end
    end else if (div_busy) begin
      case (div_sel)
        2'd0: sq_v <= {1'b0, div_quo};
        2'd1: vswr_new <= (div_quo > 33'(VSWR_MAX)) ? VSWR_MAX : div_quo[16:0];
        default: eff_new <= div_quo[16:0];
      endcase
    end

    // square root of a 33-bit value
    if (cmd.sqrt_rho) begin
      sq_r <= '0;
      sq_bit <= 34'h1 << 32;
      sq_cnt <= '0;
    end else if (sq_busy && sq_cnt != 5'd17) begin
      sq_cnt <= sq_cnt + 5'd1;
      sq_bit <= sq_bit >> 2;
      if (sq_v >= sq_rb) begin
        sq_v <= sq_v - sq_rb;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
    end else if (sq_busy) begin
      q <= (sq_r > 34'd65535) ? 16'hFFFF : sq_r[15:0];
    end
  end

  // result fields: format error blanks the power side
  assign r_status = status;
  assign r_fwd = fw;
  assign r_ref = rf;
  assign r_fdbm = (status == ST_FORMAT) ? '0 : fdbm;
  assign r_rdbm = (status == ST_FORMAT) ? '0 : rdbm;
  assign r_vswr = held_vswr;
  assign r_rl = held_return_loss;
  assign r_rho = held_rho;
  assign r_eff = held_efficiency;
  assign r_alarm = (status == ST_FORMAT) ? 1'b0 : alarm_seen;
  assign r_azp = (status == ST_FORMAT) ? 1'b0 : zero_power_digit;
  assign r_count = 16'(good_responses);

endmodule

>>> design/rpvm_checker.sv
// Port-level checker for the monitor, bound to the top level.
// Depends on rpvm_pkg.
module rpvm_checker
  import rpvm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [16:0] fwd,
  input logic [16:0] rfl
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped under stall");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken during result computation");

  a_ok_powers: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> fwd > rfl)
    else $error("ok status without forward above reflected");

  a_fmt_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FORMAT |-> fwd == 17'd0 && rfl == 17'd0)
    else $error("format error with powers");

endmodule

bind rf_power_response_vswr_monitor rpvm_checker u_rpvm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_char),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .fwd       (out_ch.forward_power),
  .rfl       (out_ch.reflected_power)
);
